// File: rtl/core/hssp_pkg.sv
// ----------------------------------------------------------------------------
// hssp_pkg: shared types and tables of the half-step stepper positioner
// Request codes, the result word layout, the coil sequence and the speed table.
// ----------------------------------------------------------------------------
package hssp_pkg;

  // Default width of the position counter, in bits.
  localparam int POSITION_BITS_DEFAULT = 12;

  localparam int REQ_W    = 2;
  localparam int TARGET_W = 16;
  localparam int SPEED_W  = 4;
  localparam int MAXPOS_W = 12;
  localparam int COILS_W  = 4;
  localparam int POS_OUT_W = 12;
  localparam int WAIT_W   = 13;
  localparam int CFG_DATA_W = 12;

  // Stream word widths; the data widths are padded to whole bytes.
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;

  // Fixed part of the inter-step wait, in ticks.
  localparam logic [WAIT_W-1:0] WAIT_BASE = 13'd500;
  // Longest wait that can ever be loaded (slowest speed).
  localparam logic [WAIT_W-1:0] WAIT_MAX  = 13'd4500;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK = 2'd0,
    REQ_MOVE = 2'd1,
    REQ_STEP = 2'd2,
    REQ_HALT = 2'd3
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_STEP_SPEED   = 1'b0,
    CFG_MAX_POSITION = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic                 rejected;
    logic                 running;
    logic [POS_OUT_W-1:0] position;
    logic [COILS_W-1:0]   coils;
  } hssp_result_t;

  // Half-step coil pattern for each of the eight phases, IN4..IN1.
  function automatic logic [COILS_W-1:0] coil_pattern(input logic [2:0] phase);
    logic [COILS_W-1:0] pat;
    case (phase)
      3'd0: pat = 4'h9;
      3'd1: pat = 4'h8;
      3'd2: pat = 4'hC;
      3'd3: pat = 4'h4;
      3'd4: pat = 4'h6;
      3'd5: pat = 4'h2;
      3'd6: pat = 4'h3;
      3'd7: pat = 4'h1;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

  // 4000 / speed, with speed clamped to 1..10.
  function automatic logic [11:0] speed_quotient(input logic [SPEED_W-1:0] speed);
    logic [11:0] quo;
    case (speed)
      4'd0, 4'd1: quo = 12'd4000;
      4'd2:       quo = 12'd2000;
      4'd3:       quo = 12'd1333;
      4'd4:       quo = 12'd1000;
      4'd5:       quo = 12'd800;
      4'd6:       quo = 12'd666;
      4'd7:       quo = 12'd571;
      4'd8:       quo = 12'd500;
      4'd9:       quo = 12'd444;
      default:    quo = 12'd400;
    endcase
    return quo;
  endfunction

endpackage

// File: rtl/core/hssp_core.sv
// ----------------------------------------------------------------------------
// hssp_core: position, phase and move state with the per-word update logic
// Applies one request per enabled cycle and presents the resulting word.
// ----------------------------------------------------------------------------
module hssp_core #(
  parameter int POSITION_BITS = hssp_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  hssp_pkg::req_type_e              req_i,
  input  logic [hssp_pkg::TARGET_W-1:0]    target_i,
  input  logic                             dir_i,
  input  logic [hssp_pkg::SPEED_W-1:0]     step_speed_i,
  input  logic [hssp_pkg::MAXPOS_W-1:0]    max_position_i,
  output hssp_pkg::hssp_result_t           result_o
);
  import hssp_pkg::*;

  logic [2:0]               phase_q, phase_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] tgt_q, tgt_d;
  logic                     active_q, active_d;
  logic [WAIT_W-1:0]        wait_q, wait_d;
  logic [COILS_W-1:0]       coil_q, coil_d;

  logic [15:0]              max_wide;
  logic [POSITION_BITS-1:0] lim;
  logic [15:0]              lim_wide;
  logic [POSITION_BITS-1:0] tgt_clamp;
  logic [WAIT_W-1:0]        wait_load;
  logic                     do_adv;
  logic                     do_single;
  logic [POSITION_BITS-1:0] adv_tgt;
  logic                     step_fwd;
  logic                     step_blocked;
  logic [2:0]               phase_next;
  logic [POSITION_BITS-1:0] pos_next;
  logic                     rejected;
  logic [15:0]              pos_wide;

  assign max_wide  = 16'(max_position_i);
  assign lim       = max_wide[POSITION_BITS-1:0];
  assign lim_wide  = 16'(lim);
  assign tgt_clamp = target_i[TARGET_W-1] ? '0 :
                     (target_i > lim_wide) ? lim : target_i[POSITION_BITS-1:0];
  assign wait_load = 13'(speed_quotient(step_speed_i)) + WAIT_BASE;

  // One half-step unit shared by moves and single steps.
  assign step_fwd     = do_adv ? (pos_q < adv_tgt) : dir_i;
  assign step_blocked = step_fwd ? (pos_q >= lim) : (pos_q == '0);
  assign phase_next   = step_fwd ? phase_q + 3'd1 : phase_q - 3'd1;
  assign pos_next     = step_fwd ? pos_q + POSITION_BITS'(1) : pos_q - POSITION_BITS'(1);

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    tgt_d     = tgt_q;
    active_d  = active_q;
    wait_d    = wait_q;
    coil_d    = coil_q;
    do_adv    = 1'b0;
    do_single = 1'b0;
    adv_tgt   = tgt_q;
    rejected  = 1'b0;

    case (req_i)
      REQ_TICK: begin
        if (active_q) begin
          if (wait_q > 13'd1) begin
            wait_d = wait_q - 13'd1;
          end else begin
            wait_d = '0;
            do_adv = 1'b1;
          end
        end
      end
      REQ_MOVE: begin
        tgt_d = tgt_clamp;
        if (pos_q != tgt_clamp) begin
          active_d = 1'b1;
          do_adv   = 1'b1;
          adv_tgt  = tgt_clamp;
        end
      end
      REQ_STEP: begin
        if (active_q) begin
          rejected = 1'b1;
        end else begin
          do_single = 1'b1;
        end
      end
      REQ_HALT: begin
        coil_d   = '0;
        active_d = 1'b0;
        wait_d   = '0;
      end
      default: begin
        rejected = 1'b0;
      end
    endcase

    if (do_adv) begin
      if (pos_q == adv_tgt || step_blocked) begin
        // Target reached or a hard limit in the way: release the coils.
        coil_d   = '0;
        active_d = 1'b0;
        wait_d   = '0;
      end else begin
        phase_d = phase_next;
        pos_d   = pos_next;
        coil_d  = coil_pattern(phase_next);
        wait_d  = wait_load;
      end
    end

    if (do_single) begin
      if (step_blocked) begin
        rejected = 1'b1;
      end else begin
        phase_d = phase_next;
        pos_d   = pos_next;
        coil_d  = coil_pattern(phase_next);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      pos_q    <= '0;
      tgt_q    <= '0;
      active_q <= 1'b0;
      wait_q   <= '0;
      coil_q   <= '0;
    end else if (valid_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      tgt_q    <= tgt_d;
      active_q <= active_d;
      wait_q   <= wait_d;
      coil_q   <= coil_d;
    end
  end

  assign pos_wide          = 16'(pos_d);
  assign result_o.coils    = coil_d;
  assign result_o.position = pos_wide[POS_OUT_W-1:0];
  assign result_o.running  = active_d;
  assign result_o.rejected = rejected;

`ifndef NO_ASSERTIONS
  // An idle positioner never holds a pending wait.
  a_idle_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> wait_q == '0)
    else $error("wait count nonzero while no move is active");

  // A running move always keeps the coils energized.
  a_move_energized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> coil_q != '0)
    else $error("move active with coils released");

  // The countdown never exceeds the slowest loaded wait.
  a_wait_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q <= WAIT_MAX)
    else $error("wait count above its maximum load");

  // Coil drive always matches the current phase unless released.
  a_coil_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coil_q == '0 || coil_q == coil_pattern(phase_q))
    else $error("coil drive does not match phase");
`endif

endmodule

// File: rtl/core/hssp_skid.sv
// ----------------------------------------------------------------------------
// hssp_skid: two-entry output buffer for result words
// Holds a finished word while the downstream side stalls, at full rate.
// ----------------------------------------------------------------------------
module hssp_skid (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  hssp_pkg::hssp_result_t push_data_i,
  output logic                   push_ready_o,
  output logic                   out_valid_o,
  output hssp_pkg::hssp_result_t out_data_o,
  input  logic                   out_ready_i
);
  import hssp_pkg::*;

  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  hssp_result_t main_data_q, main_data_d;
  hssp_result_t skid_data_q, skid_data_d;
  logic         main_free;

  assign push_ready_o = !skid_valid_q;
  assign main_free    = !main_valid_q || out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_data_d  = main_data_q;
    skid_data_d  = skid_data_q;
    if (main_free) begin
      main_valid_d = skid_valid_q || push_i;
      main_data_d  = skid_valid_q ? skid_data_q : push_data_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_data_q <= main_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_data_q;

`ifndef NO_ASSERTIONS
  // The spare entry only fills behind an occupied output entry.
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry valid with empty output entry");

  // A word parked in the spare entry moves to the output once it drains.
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_ready_i |=> main_valid_q && !skid_valid_q)
    else $error("skid entry did not advance");

  // No push is taken while both entries are full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_ready_i |=> skid_valid_q && main_valid_q)
    else $error("buffer lost a word under stall");
`endif

endmodule

// File: rtl/core/half_step_stepper_positioner.sv
// ----------------------------------------------------------------------------
// half_step_stepper_positioner: half-step stepper sequencer with position
// A word held in the input register is applied once the output buffer has
// room; its result word is then offered from that buffer to the master side.
// Throughput: one word per cycle while the buffer has room; the update is
// one pass of compare, increment and table lookup, input register to state.
// Reset: asynchronous, active low; position, phase and move state clear,
// coils released, step_speed 5 and max_position 1800.
// ----------------------------------------------------------------------------
module half_step_stepper_positioner #(
  parameter int POSITION_BITS = hssp_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Slave side: request words.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata fields, low bit up: target[15:0] (signed), dir[16], zero pad.
  input  logic [hssp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser fields: req_type[1:0].
  input  logic [hssp_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  // Master side: result words.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata fields, low bit up: coils[3:0], position[15:4], running[16],
  // rejected[17], zero pad.
  output logic [hssp_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [hssp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import hssp_pkg::*;

  // Configuration registers.
  logic [SPEED_W-1:0]  step_speed_q;
  logic [MAXPOS_W-1:0] max_position_q;

  // Input register: one request word waiting to be applied.
  logic                in_valid_q, in_valid_d;
  req_type_e           in_req_q;
  logic [TARGET_W-1:0] in_target_q;
  logic                in_dir_q;

  logic                s_fire;
  logic                apply;
  logic                push_ready;
  hssp_result_t        core_result;
  hssp_result_t        out_result;

  // Configuration is always accepted; it is only to be written while the block idles, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_speed_q   <= 4'd5;
      max_position_q <= 12'd1800;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_STEP_SPEED:   step_speed_q   <= cfg_data_i[SPEED_W-1:0];
        CFG_MAX_POSITION: max_position_q <= cfg_data_i[MAXPOS_W-1:0];
        default:          step_speed_q   <= step_speed_q;
      endcase
    end
  end

  // The held word is applied as soon as the output buffer has room, so the
  // input register refills in the same cycle and words stream at full rate.
  assign apply         = in_valid_q && push_ready;
  assign s_axis_tready = !in_valid_q || push_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (apply) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_req_q    <= req_type_e'(s_axis_tuser);
      in_target_q <= s_axis_tdata[TARGET_W-1:0];
      in_dir_q    <= s_axis_tdata[TARGET_W];
    end
  end

  hssp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (apply),
    .req_i          (in_req_q),
    .target_i       (in_target_q),
    .dir_i          (in_dir_q),
    .step_speed_i   (step_speed_q),
    .max_position_i (max_position_q),
    .result_o       (core_result)
  );

  hssp_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (apply),
    .push_data_i  (core_result),
    .push_ready_o (push_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (out_result),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = M_TDATA_W'(out_result);

`ifndef NO_ASSERTIONS
  // Back-pressure on the slave side only ever comes from a held word.
  a_ready_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q)
    else $error("slave side stalled with empty input register");

  // An applied word always yields a result word on the master side.
  a_apply_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply |=> m_axis_tvalid)
    else $error("applied word produced no result word");

  // The padding bits of a result word are always zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:18] == '0)
    else $error("nonzero padding in result word");
`endif

endmodule

// File: verif/tb_half_step_stepper_positioner.sv
// ----------------------------------------------------------------------------
// tb_half_step_stepper_positioner: self-checking bench of the stepper positioner
// Request words go in on the slave stream and the bench predicts the coil
// drive, position, running and rejected flags of every result word. A short
// table of directed words comes first, then three random phases with changed
// registers and changed idling on both sides. The receiver holds off once.
// ----------------------------------------------------------------------------
module tb_half_step_stepper_positioner;
  import hssp_pkg::*;

  // A quiet stretch this long means the block has hung.
  localparam int unsigned QUIET_LIMIT    = 4000;
  // Cycles allowed for a word still in flight before a register write.
  localparam int unsigned SETTLE_CYCLES  = 4;
  // The receiver holds off once, after this many request words.
  localparam int unsigned PRESSURE_AFTER = 300;
  localparam int unsigned HOLD_CYCLES    = 300;
  // Non-tick request words in each random phase.
  localparam int unsigned PHASE_WORDS    = 10;

  // Half-step coil sequence, IN4..IN1, and 4000/speed for speeds 1..10.
  localparam logic [COILS_W-1:0] HALF_STEP_COILS [8] =
    '{4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};
  localparam int unsigned SPEED_DIV [10] =
    '{4000, 2000, 1333, 1000, 800, 666, 571, 500, 444, 400};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i   = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  half_step_stepper_positioner u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Positioner prediction: a private copy of the registers and motor state.
  // --------------------------------------------------------------------------
  logic [SPEED_W-1:0]  cfg_speed;
  logic [MAXPOS_W-1:0] cfg_limit;
  logic [2:0]          st_phase;
  logic [11:0]         st_pos;
  logic [11:0]         st_goal;
  logic                st_moving;
  logic [WAIT_W-1:0]   st_countdown;
  logic [COILS_W-1:0]  st_coils;

  // Result words still owed by the block, oldest first.
  hssp_result_t pending_drive_states [$];

  int unsigned mismatch_count = 0;
  int unsigned words_sent     = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_idle_pct  = 0;

  // Inter-step wait: speed 0 behaves as 1 and anything above 10 as 10.
  function automatic logic [WAIT_W-1:0] step_interval();
    int unsigned s;
    s = cfg_speed;
    if (s < 1) s = 1;
    if (s > 10) s = 10;
    return WAIT_W'(SPEED_DIV[s-1] + 500);
  endfunction

  // One half-step in the given direction, refused at either hard limit.
  function automatic bit half_step(input bit fwd);
    if (fwd) begin
      if (st_pos >= cfg_limit) return 1'b0;
      st_phase = st_phase + 3'd1;
      st_pos   = st_pos + 12'd1;
    end else begin
      if (st_pos == '0) return 1'b0;
      st_phase = st_phase - 3'd1;
      st_pos   = st_pos - 12'd1;
    end
    st_coils = HALF_STEP_COILS[st_phase];
    return 1'b1;
  endfunction

  function automatic void release_coils();
    st_coils     = '0;
    st_moving    = 1'b0;
    st_countdown = '0;
  endfunction

  // Step toward the goal; the move ends when the goal is reached or blocked.
  function automatic void approach_goal();
    if (st_pos == st_goal) begin
      release_coils();
    end else if (half_step(st_pos < st_goal)) begin
      st_countdown = step_interval();
    end else begin
      release_coils();
    end
  endfunction

  function automatic hssp_result_t advance_positioner(input req_type_e req,
                                                      input logic [15:0] tgt,
                                                      input logic fwd);
    hssp_result_t res;
    logic         rej;
    rej = 1'b0;
    case (req)
      REQ_TICK: begin
        if (st_moving) begin
          if (st_countdown > 1) begin
            st_countdown = st_countdown - 1'b1;
          end else begin
            st_countdown = '0;
            approach_goal();
          end
        end
      end
      REQ_MOVE: begin
        // Negative targets clamp to zero, large ones to the upper limit.
        if (tgt[15]) st_goal = '0;
        else if (tgt > {4'b0, cfg_limit}) st_goal = cfg_limit;
        else st_goal = tgt[11:0];
        if (st_pos != st_goal) begin
          st_moving = 1'b1;
          approach_goal();
        end
      end
      REQ_STEP: begin
        if (st_moving) rej = 1'b1;
        else if (!half_step(fwd)) rej = 1'b1;
      end
      default: begin
        release_coils();
      end
    endcase
    res.rejected = rej;
    res.running  = st_moving;
    res.position = st_pos;
    res.coils    = st_coils;
    return res;
  endfunction

  function automatic hssp_result_t drive_state(input logic rej, input logic run,
                                               input int unsigned pos,
                                               input logic [3:0] coils);
    hssp_result_t res;
    res.rejected = rej;
    res.running  = run;
    res.position = POS_OUT_W'(pos);
    res.coils    = coils;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. The valid stays high across back-to-back words and only
  // drops for idle cycles and register writes, so it gets one update per time step.
  // --------------------------------------------------------------------------
  task automatic send_word(input req_type_e req, input logic [15:0] tgt,
                           input logic fwd, input bit typed, input hssp_result_t want);
    hssp_result_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, fwd, tgt};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    predicted = advance_positioner(req, tgt, fwd);
    pending_drive_states.push_back(typed ? want : predicted);
  endtask

  task automatic send_ticks(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      send_word(REQ_TICK, 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                1'b0, '0);
    end
  endtask

  // Registers change only once every owed result word has come back.
  task automatic write_register(input cfg_index_e idx, input logic [11:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_drive_states.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_STEP_SPEED) cfg_speed = val[SPEED_W-1:0];
    else cfg_limit = val[MAXPOS_W-1:0];
  endtask

  // Mostly moves a few steps away, so that moves start and retarget, with
  // short tick runs in between; countdown expiry is covered by the table.
  task automatic run_random_phase(input int unsigned quota);
    int unsigned done;
    int unsigned pick;
    int          base;
    logic [15:0] tgt;
    done = 0;
    while (done < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if (pick < 10) tgt = 16'($urandom_range(0, 16'hFFFF));
        else begin
          base = ($urandom_range(0, 3) == 0) ? int'(cfg_limit) : int'(st_pos);
          tgt  = 16'(base + int'($urandom_range(0, 6)) - 3);
        end
        send_word(REQ_MOVE, tgt, 1'($urandom_range(0, 1)), 1'b0, '0);
        send_ticks($urandom_range(0, 10));
      end else if (pick < 77) begin
        send_word(REQ_STEP, 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                  1'b0, '0);
      end else if (pick < 85) begin
        send_word(REQ_HALT, 16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                  1'b0, '0);
      end else begin
        send_ticks($urandom_range(1, 20));
        continue;
      end
      done++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold-off that fills the
  // block and stalls its input.
  // --------------------------------------------------------------------------
  int unsigned hold_left;
  bit          held_once;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      held_once     <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!held_once && words_sent >= PRESSURE_AFTER) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      held_once     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    hssp_result_t got;
    hssp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = hssp_result_t'(m_axis_tdata[17:0]);
      if (pending_drive_states.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_drive_states.pop_front();
        if (got.coils != want.coils) begin
          $error("coils: expected %h, actual %h", want.coils, got.coils);
          mismatch_count++;
        end
        if (got.position != want.position) begin
          $error("position: expected %0d, actual %0d", want.position, got.position);
          mismatch_count++;
        end
        if (got.running != want.running) begin
          $error("running: expected %0d, actual %0d", want.running, got.running);
          mismatch_count++;
        end
        if (got.rejected != want.rejected) begin
          $error("rejected: expected %0d, actual %0d", want.rejected, got.rejected);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("half_step_stepper_positioner test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Directed table, then the random phases.
  // --------------------------------------------------------------------------
  typedef struct {
    bit           write_cfg;
    cfg_index_e   reg_sel;
    logic [11:0]  reg_val;
    req_type_e    req;
    logic [15:0]  tgt;
    logic         fwd;
    int unsigned  reps;
    bit           typed;
    hssp_result_t want;
  } plan_row_t;

  plan_row_t plan [25];

  initial begin
    cfg_speed    = 4'd5;
    cfg_limit    = 12'd1800;
    st_phase     = '0;
    st_pos       = '0;
    st_goal      = '0;
    st_moving    = 1'b0;
    st_countdown = '0;
    st_coils     = '0;

    plan = '{
      // Tick while idle does nothing.
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_TICK, 16'h7FFF, 1'b1, 1, 1'b1,
        drive_state(1'b0, 1'b0, 0, 4'h0)},
      // Reverse step at zero is refused and leaves the coils alone.
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_STEP, 16'h0000, 1'b0, 1, 1'b1,
        drive_state(1'b1, 1'b0, 0, 4'h0)},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_STEP, 16'hFFFF, 1'b1, 1, 1'b1,
        drive_state(1'b0, 1'b0, 1, 4'h8)},
      // Move to where the motor already is: no step, coils stay driven.
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_MOVE, 16'h0001, 1'b0, 1, 1'b0, '0},
      // Most negative target clamps to zero.
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_MOVE, 16'h8000, 1'b1, 1, 1'b0, '0},
      // Single step during a move is refused.
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_STEP, 16'h5555, 1'b1, 1, 1'b0, '0},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_TICK, 16'hAAAA, 1'b0, 1, 1'b0, '0},
      // Retarget during a move to the largest positive target.
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_MOVE, 16'h7FFF, 1'b0, 1, 1'b0, '0},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_HALT, 16'h1234, 1'b1, 1, 1'b1,
        drive_state(1'b0, 1'b0, 1, 4'h0)},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_HALT, 16'h0000, 1'b0, 1, 1'b1,
        drive_state(1'b0, 1'b0, 1, 4'h0)},
      // Speed above ten acts as ten; widest limit.
      '{1'b1, CFG_STEP_SPEED, 12'd15, REQ_TICK, 16'h0000, 1'b0, 0, 1'b0, '0},
      '{1'b1, CFG_MAX_POSITION, 12'd4095, REQ_TICK, 16'h0000, 1'b0, 0, 1'b0, '0},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_MOVE, 16'h0FFF, 1'b0, 1, 1'b0, '0},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_TICK, 16'h0000, 1'b0, 899, 1'b0, '0},
      // Limit dropped below the goal mid-move: the next step is blocked and
      // the move ends with the coils released.
      '{1'b1, CFG_MAX_POSITION, 12'd0, REQ_TICK, 16'h0000, 1'b0, 0, 1'b0, '0},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_TICK, 16'h0000, 1'b0, 1, 1'b1,
        drive_state(1'b0, 1'b0, 2, 4'h0)},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_STEP, 16'h0000, 1'b1, 1, 1'b1,
        drive_state(1'b1, 1'b0, 2, 4'h0)},
      // Reverse step is still allowed above the limit.
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_STEP, 16'h0000, 1'b0, 1, 1'b0, '0},
      // One step to the clamped goal, then the countdown expires with the
      // goal reached and the coils are released.
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_MOVE, 16'h0005, 1'b0, 1, 1'b0, '0},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_TICK, 16'h0000, 1'b0, 900, 1'b1,
        drive_state(1'b0, 1'b0, 0, 4'h0)},
      // Speed zero acts as one: the next move loads the longest wait.
      '{1'b1, CFG_STEP_SPEED, 12'd0, REQ_TICK, 16'h0000, 1'b0, 0, 1'b0, '0},
      '{1'b1, CFG_MAX_POSITION, 12'd4095, REQ_TICK, 16'h0000, 1'b0, 0, 1'b0, '0},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_MOVE, 16'h0002, 1'b0, 1, 1'b0, '0},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_STEP, 16'h0000, 1'b1, 1, 1'b1,
        drive_state(1'b1, 1'b1, 1, 4'h8)},
      '{1'b0, CFG_STEP_SPEED, 12'd0, REQ_TICK, 16'hFFFF, 1'b1, 3, 1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct  = 17;
    sink_idle_pct = 81;
    foreach (plan[i]) begin
      if (plan[i].write_cfg) begin
        write_register(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        for (int unsigned k = 0; k < plan[i].reps; k++) begin
          send_word(plan[i].req, plan[i].tgt, plan[i].fwd,
                    plan[i].typed && (k == plan[i].reps - 1), plan[i].want);
        end
      end
    end

    // Fast steps against a small limit, so both limits are hit often.
    write_register(CFG_STEP_SPEED, 12'($urandom_range(10, 15)));
    write_register(CFG_MAX_POSITION, 12'($urandom_range(6, 40)));
    run_random_phase(PHASE_WORDS);

    src_idle_pct  = 81;
    sink_idle_pct = 17;
    write_register(CFG_STEP_SPEED, 12'($urandom_range(4, 15)));
    write_register(CFG_MAX_POSITION, 12'd4095);
    run_random_phase(PHASE_WORDS);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_register(CFG_STEP_SPEED, 12'($urandom_range(1, 10)));
    write_register(CFG_MAX_POSITION, 12'($urandom_range(1, 60)));
    run_random_phase(PHASE_WORDS);

    s_axis_tvalid <= 1'b0;
    while (pending_drive_states.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("half_step_stepper_positioner test passed");
    end else begin
      $display("half_step_stepper_positioner test failed");
    end
    $finish;
  end

endmodule
